### design/lpfbc_pkg.sv
// ----------------------------------------------------------------------------
// Four-channel lowpass with bias calibration: shared package
// Widths, codes, reset values and the types that pass between the
// sequencer, the shared multiplier and the serial divider.
// ----------------------------------------------------------------------------
package lpfbc_pkg;

   // Sample and coefficient formats.
   localparam int SAMPLE_BITS    = 10;
   localparam int COEF_FRAC_BITS = 16;
   localparam int COEF_BITS      = 16;
   localparam int Y_BITS         = SAMPLE_BITS + COEF_FRAC_BITS;
   localparam int GRIP_BITS      = SAMPLE_BITS + 1;
   localparam int PAIR_BITS      = SAMPLE_BITS + 1;

   // Shared multiplier: coefficient times filter word.
   localparam int PROD_BITS = COEF_BITS + Y_BITS;

   // Calibration accumulation and the bias division.
   localparam int CNT_BITS      = 16;
   localparam int SUM_BITS      = Y_BITS + CNT_BITS;
   localparam int DIVIDEND_BITS = SUM_BITS + 1 - COEF_FRAC_BITS;
   localparam int REM_BITS      = CNT_BITS + 1;
   localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);

   // Channels.
   localparam int NUM_CH  = 4;
   localparam int CH_BITS = 2;
   localparam logic [CH_BITS-1:0] CH_BACK  = CH_BITS'(2);
   localparam logic [CH_BITS-1:0] CH_FORCE = CH_BITS'(3);
   localparam logic [CH_BITS-1:0] CH_LAST  = CH_BITS'(NUM_CH - 1);

   // Configuration register reset values.
   localparam logic [COEF_BITS-1:0] COEF_INPUT_RESET    = COEF_BITS'(8959);
   localparam logic [COEF_BITS-1:0] COEF_FEEDBACK_RESET = COEF_BITS'(47612);
   localparam logic [CNT_BITS-1:0]  CALIB_SAMPLES_RESET = CNT_BITS'(100);

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CMD_BITS       = 2;

   // Request commands.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_MEASURE = 2'd0,
      CMD_START   = 2'd1,
      CMD_CALIB   = 2'd2
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_INPUT    = 2'd0,
      CSR_COEF_FEEDBACK = 2'd1,
      CSR_CALIB_SAMPLES = 2'd2
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_FB,
      ST_MUL_IN,
      ST_UPDATE,
      ST_COUNT,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   // Divider command and status.
   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [CNT_BITS-1:0]      divisor;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### design/lpfbc_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries the command and the four raw ADC samples of one request.
// ----------------------------------------------------------------------------
interface lpfbc_req_if;
   import lpfbc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CMD_BITS-1:0]    cmd;
   logic [SAMPLE_BITS-1:0] left_sample;
   logic [SAMPLE_BITS-1:0] right_sample;
   logic [SAMPLE_BITS-1:0] back_sample;
   logic [SAMPLE_BITS-1:0] force_sample;

   modport source (
      output valid, cmd, left_sample, right_sample, back_sample, force_sample,
      input  ready
   );

   modport sink (
      input  valid, cmd, left_sample, right_sample, back_sample, force_sample,
      output ready
   );
endinterface

### design/lpfbc_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries the four force readings and the calibration flags of one request.
// ----------------------------------------------------------------------------
interface lpfbc_rsp_if;
   import lpfbc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [SAMPLE_BITS-1:0]      left_force;
   logic [SAMPLE_BITS-1:0]      right_force;
   logic [SAMPLE_BITS-1:0]      back_force;
   logic signed [GRIP_BITS-1:0] grip_force;
   logic                        is_calibrated;
   logic                        in_calibration;

   modport source (
      output valid, left_force, right_force, back_force, grip_force,
             is_calibrated, in_calibration,
      input  ready
   );

   modport sink (
      input  valid, left_force, right_force, back_force, grip_force,
             is_calibrated, in_calibration,
      output ready
   );
endinterface

### design/lpfbc_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and the data written to it.
// ----------------------------------------------------------------------------
interface lpfbc_csr_if;
   import lpfbc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );

   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

### design/lpfbc_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Multiplies a 16-bit coefficient by a filter word; the product is
// registered and appears in the cycle after the operands.
// ----------------------------------------------------------------------------
module lpfbc_mul (
   input  logic                             clock,
   input  logic [lpfbc_pkg::COEF_BITS-1:0]  op_a,
   input  logic [lpfbc_pkg::Y_BITS-1:0]     op_b,
   output logic [lpfbc_pkg::PROD_BITS-1:0]  prod
);
   import lpfbc_pkg::*;

   logic [PROD_BITS-1:0] prod_ff;

   // Registered product.
   always_ff @(posedge clock) begin
      prod_ff <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
   end

   assign prod = prod_ff;
endmodule

### design/lpfbc_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when the quotient is complete.
// ----------------------------------------------------------------------------
module lpfbc_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lpfbc_pkg::div_cmd_type               cmd,
   output lpfbc_pkg::div_status_type            status,
   output logic [lpfbc_pkg::DIVIDEND_BITS-1:0]  quotient
);
   import lpfbc_pkg::*;

   logic [REM_BITS-1:0]      rem_ff,     rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff,     quo_in;
   logic [CNT_BITS-1:0]      divisor_ff, divisor_in;
   logic [DIV_CNT_BITS-1:0]  step_ff,    step_in;
   logic                     busy_ff,    busy_in;
   logic                     done_ff,    done_in;
   logic [REM_BITS-1:0]      rem_shift;
   logic [REM_BITS-1:0]      rem_diff;
   logic                     fits;

   // One restoring step: shift in the next dividend bit and try the divisor.
   always_comb begin
      rem_shift = {rem_ff[REM_BITS-2:0], quo_ff[DIVIDEND_BITS-1]};
      fits      = rem_shift >= {1'b0, divisor_ff};
      rem_diff  = rem_shift - {1'b0, divisor_ff};

      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;

      if (cmd.start) begin
         rem_in     = '0;
         quo_in     = cmd.dividend;
         divisor_in = cmd.divisor;
         step_in    = DIV_CNT_BITS'(DIVIDEND_BITS);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_diff : rem_shift;
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
         step_in = step_ff - DIV_CNT_BITS'(1);
         if (step_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand registers.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
endmodule

### design/four_channel_lpf_bias_calibration_top.sv
// ----------------------------------------------------------------------------
// Four-channel lowpass with bias calibration
// Filters four ADC channels with a first-order IIR lowpass and reports each
// one against its calibrated bias.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A sequencer runs the four channels
// through one shared multiplier, in the states MUL_FB, MUL_IN and UPDATE per
// channel, for a measure or calibration sample; a start command or an ignored
// request goes straight to the response. The calibration sample that
// closes a run also computes the four biases on one serial divider, one
// quotient bit per cycle for a 27-bit quotient, after a load state per channel.
// The response is held in an output register, so the next request is accepted
// while the previous response waits; configuration writes are taken in any
// cycle and must only be issued while the block is idle.
module four_channel_lpf_bias_calibration_top (
   input  logic         clock,
   input  logic         reset,
   lpfbc_req_if.sink    req_port,
   lpfbc_rsp_if.source  rsp_port,
   lpfbc_csr_if.sink    csr_port
);
   import lpfbc_pkg::*;

   // Configuration registers.
   logic [COEF_BITS-1:0] coef_input_ff,    coef_input_in;
   logic [COEF_BITS-1:0] coef_feedback_ff, coef_feedback_in;
   logic [CNT_BITS-1:0]  calib_samples_ff, calib_samples_in;

   // Sequencer.
   state_type            state_ff, state_in;
   logic [CH_BITS-1:0]   ch_ff,    ch_in;
   logic                 calib_mode_ff, calib_mode_in;
   logic                 req_accept;
   cmd_type              req_cmd;

   // Filter and calibration state.
   logic [SAMPLE_BITS-1:0] x_ff    [NUM_CH];
   logic [SAMPLE_BITS-1:0] x_in    [NUM_CH];
   logic [SAMPLE_BITS-1:0] xp_ff   [NUM_CH];
   logic [SAMPLE_BITS-1:0] xp_in   [NUM_CH];
   logic [Y_BITS-1:0]      y_ff    [NUM_CH];
   logic [Y_BITS-1:0]      y_in    [NUM_CH];
   logic [SAMPLE_BITS-1:0] bias_ff [NUM_CH];
   logic [SAMPLE_BITS-1:0] bias_in [NUM_CH];
   logic [SUM_BITS-1:0]    sum_ff  [NUM_CH];
   logic [SUM_BITS-1:0]    sum_in  [NUM_CH];
   logic [GRIP_BITS-1:0]   res_ff  [NUM_CH];
   logic [GRIP_BITS-1:0]   res_in  [NUM_CH];
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   calibrated_ff, calibrated_in;
   logic                   calibrating_ff, calibrating_in;
   logic [Y_BITS-1:0]      fb_ff, fb_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GRIP_BITS-1:0]   rsp_res_ff [NUM_CH];
   logic [GRIP_BITS-1:0]   rsp_res_in [NUM_CH];
   logic                   rsp_cal_ff,  rsp_cal_in;
   logic                   rsp_run_ff,  rsp_run_in;
   logic                   rsp_load;

   // Shared units.
   logic [COEF_BITS-1:0]     mul_a;
   logic [Y_BITS-1:0]        mul_b;
   logic [PROD_BITS-1:0]     mul_prod;
   div_cmd_type              div_cmd;
   div_status_type           div_status;
   logic [DIVIDEND_BITS-1:0] div_quo;

   // Datapath intermediates.
   logic [PAIR_BITS-1:0]   pair_sum;
   logic [PROD_BITS-1:0]   fb_round;
   logic [Y_BITS+1:0]      y_raw;
   logic [Y_BITS-1:0]      y_new;
   logic [Y_BITS:0]        diff;
   logic [Y_BITS:0]        diff_neg;
   logic [SAMPLE_BITS-1:0] mag_pos;
   logic [SAMPLE_BITS-1:0] mag_neg;
   logic [CNT_BITS-1:0]    count_next;
   logic [SUM_BITS:0]      bias_num;
   logic [SAMPLE_BITS-1:0] bias_sat;

   lpfbc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   lpfbc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .status   (div_status),
      .quotient (div_quo)
   );

   assign req_accept = req_port.valid && req_port.ready;
   assign req_cmd    = cmd_type'(req_port.cmd);
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_port.ready);

   // Next calibration count: wraps past zero to one.
   assign count_next = ((count_ff + CNT_BITS'(1)) == '0) ? CNT_BITS'(1)
                                                         : count_ff + CNT_BITS'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_cmd)
                  CMD_MEASURE: state_in = ST_MUL_FB;
                  CMD_CALIB:   state_in = calibrating_ff ? ST_MUL_FB : ST_DONE;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_MUL_FB: state_in = ST_MUL_IN;
         ST_MUL_IN: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (ch_ff != CH_LAST) begin
               state_in = ST_MUL_FB;
            end else begin
               state_in = calib_mode_ff ? ST_COUNT : ST_DONE;
            end
         end
         ST_COUNT: begin
            state_in = (count_next >= calib_samples_ff) ? ST_DIV_LOAD : ST_DONE;
         end
         ST_DIV_LOAD: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               state_in = (ch_ff == CH_LAST) ? ST_DONE : ST_DIV_LOAD;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake and shared unit operands.
   always_comb begin
      req_port.ready   = 1'b0;
      mul_a            = '0;
      mul_b            = '0;
      div_cmd.start    = 1'b0;
      bias_num         = {1'b0, sum_ff[ch_ff]}
                         + ((SUM_BITS+1)'(count_ff) << (COEF_FRAC_BITS - 1));
      div_cmd.dividend = bias_num[SUM_BITS:COEF_FRAC_BITS];
      div_cmd.divisor  = count_ff;
      case (state_ff)
         ST_IDLE:     req_port.ready = 1'b1;
         ST_MUL_FB: begin
            mul_a = coef_feedback_ff;
            mul_b = y_ff[ch_ff];
         end
         ST_MUL_IN: begin
            mul_a = coef_input_ff;
            mul_b = Y_BITS'(pair_sum);
         end
         ST_DIV_LOAD: div_cmd.start = 1'b1;
         default: ;
      endcase
   end

   // Filter arithmetic and force difference for the current channel.
   always_comb begin
      pair_sum = {1'b0, x_ff[ch_ff]} + {1'b0, xp_ff[ch_ff]};
      fb_round = mul_prod + (PROD_BITS'(1) << (COEF_FRAC_BITS - 1));
      y_raw    = {2'b00, fb_ff} + {1'b0, mul_prod[Y_BITS:0]};
      y_new    = (y_raw[Y_BITS+1:Y_BITS] != 2'b00) ? '1 : y_raw[Y_BITS-1:0];
      diff     = {1'b0, y_new} - {1'b0, bias_ff[ch_ff], {COEF_FRAC_BITS{1'b0}}};
      diff_neg = -diff;
      mag_pos  = diff[Y_BITS-1:COEF_FRAC_BITS];
      mag_neg  = diff_neg[Y_BITS-1:COEF_FRAC_BITS];
      bias_sat = (div_quo[DIVIDEND_BITS-1:SAMPLE_BITS] != '0) ? '1
                                                             : div_quo[SAMPLE_BITS-1:0];
   end

   // Datapath next values.
   always_comb begin
      x_in           = x_ff;
      xp_in          = xp_ff;
      y_in           = y_ff;
      bias_in        = bias_ff;
      sum_in         = sum_ff;
      res_in         = res_ff;
      count_in       = count_ff;
      calibrated_in  = calibrated_ff;
      calibrating_in = calibrating_ff;
      fb_in          = fb_ff;
      ch_in          = ch_ff;
      calib_mode_in  = calib_mode_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               x_in[0]       = req_port.left_sample;
               x_in[1]       = req_port.right_sample;
               x_in[2]       = req_port.back_sample;
               x_in[3]       = req_port.force_sample;
               ch_in         = '0;
               calib_mode_in = (req_cmd == CMD_CALIB);
               for (int i = 0; i < NUM_CH; i++) begin
                  res_in[i] = '0;
               end
               // A start command opens a fresh calibration run.
               if (req_cmd == CMD_START) begin
                  for (int i = 0; i < NUM_CH; i++) begin
                     bias_in[i] = '0;
                     sum_in[i]  = '0;
                  end
                  count_in       = '0;
                  calibrating_in = 1'b1;
               end
            end
         end
         ST_MUL_IN: begin
            fb_in = fb_round[PROD_BITS-1:COEF_FRAC_BITS];
         end
         ST_UPDATE: begin
            y_in[ch_ff]  = y_new;
            xp_in[ch_ff] = x_ff[ch_ff];
            if (calib_mode_ff) begin
               sum_in[ch_ff] = sum_ff[ch_ff] + SUM_BITS'(y_new);
            end else begin
               // Back is inverted; grip is signed; the others clamp at zero.
               if (ch_ff == CH_BACK) begin
                  res_in[ch_ff] = diff[Y_BITS] ? {1'b0, mag_neg} : '0;
               end else if (ch_ff == CH_FORCE) begin
                  res_in[ch_ff] = diff[Y_BITS] ? -{1'b0, mag_neg} : {1'b0, mag_pos};
               end else begin
                  res_in[ch_ff] = diff[Y_BITS] ? '0 : {1'b0, mag_pos};
               end
            end
            ch_in = ch_ff + CH_BITS'(1);
         end
         ST_COUNT: begin
            count_in = count_next;
            ch_in    = '0;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               bias_in[ch_ff] = bias_sat;
               ch_in          = ch_ff + CH_BITS'(1);
               if (ch_ff == CH_LAST) begin
                  calibrating_in = 1'b0;
                  calibrated_in  = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // Configuration writes.
   always_comb begin
      csr_port.ready   = 1'b1;
      coef_input_in    = coef_input_ff;
      coef_feedback_in = coef_feedback_ff;
      calib_samples_in = calib_samples_ff;
      if (csr_port.valid) begin
         case (csr_index_type'(csr_port.index))
            CSR_COEF_INPUT:    coef_input_in    = COEF_BITS'(csr_port.data);
            CSR_COEF_FEEDBACK: coef_feedback_in = COEF_BITS'(csr_port.data);
            CSR_CALIB_SAMPLES: calib_samples_in = CNT_BITS'(csr_port.data);
            default: ;
         endcase
      end
   end

   // Response register: loaded when the request finishes, cleared when taken.
   always_comb begin
      rsp_res_in = rsp_res_ff;
      rsp_cal_in = rsp_cal_ff;
      rsp_run_in = rsp_run_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res_ff;
         rsp_cal_in   = calibrated_ff;
         rsp_run_in   = calibrating_ff;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and filter state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         ch_ff            <= '0;
         calib_mode_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         coef_input_ff    <= COEF_INPUT_RESET;
         coef_feedback_ff <= COEF_FEEDBACK_RESET;
         calib_samples_ff <= CALIB_SAMPLES_RESET;
         count_ff         <= '0;
         calibrated_ff    <= 1'b0;
         calibrating_ff   <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            xp_ff[i]   <= '0;
            y_ff[i]    <= '0;
            bias_ff[i] <= '0;
            sum_ff[i]  <= '0;
         end
      end else begin
         state_ff         <= state_in;
         ch_ff            <= ch_in;
         calib_mode_ff    <= calib_mode_in;
         rsp_valid_ff     <= rsp_valid_in;
         coef_input_ff    <= coef_input_in;
         coef_feedback_ff <= coef_feedback_in;
         calib_samples_ff <= calib_samples_in;
         count_ff         <= count_in;
         calibrated_ff    <= calibrated_in;
         calibrating_ff   <= calibrating_in;
         xp_ff            <= xp_in;
         y_ff             <= y_in;
         bias_ff          <= bias_in;
         sum_ff           <= sum_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      res_ff     <= res_in;
      fb_ff      <= fb_in;
      rsp_res_ff <= rsp_res_in;
      rsp_cal_ff <= rsp_cal_in;
      rsp_run_ff <= rsp_run_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.left_force     = rsp_res_ff[0][SAMPLE_BITS-1:0];
   assign rsp_port.right_force    = rsp_res_ff[1][SAMPLE_BITS-1:0];
   assign rsp_port.back_force     = rsp_res_ff[2][SAMPLE_BITS-1:0];
   assign rsp_port.grip_force     = rsp_res_ff[3];
   assign rsp_port.is_calibrated  = rsp_cal_ff;
   assign rsp_port.in_calibration = rsp_run_ff;
endmodule
